### rtl/tvrp_pkg.sv
// tvrp_pkg: shared types and constants of the typed value record parser
// no dependencies; used by tvrp_ctrl, tvrp_dpath and the top level
package tvrp_pkg;

  // result kinds
  localparam logic [1:0] KIND_NUMERIC  = 2'd0;
  localparam logic [1:0] KIND_STRING   = 2'd1;
  localparam logic [1:0] KIND_INVALID  = 2'd2;
  localparam logic [1:0] KIND_TOO_LONG = 2'd3;

  // record type codes
  localparam logic [7:0] TYPE_NUM_SHORT = 8'd1;
  localparam logic [7:0] TYPE_NUM_LONG  = 8'd3;
  localparam logic [7:0] TYPE_STRING    = 8'd4;

  // record offsets
  localparam int POS_W = 4;
  localparam logic [POS_W-1:0] POS_ID        = 4'd0;
  localparam logic [POS_W-1:0] POS_TYPE      = 4'd1;
  localparam logic [POS_W-1:0] POS_BODY      = 4'd2;
  localparam logic [POS_W-1:0] POS_SHORT_LST = 4'd5;
  localparam logic [POS_W-1:0] POS_SHORT_END = 4'd6;
  localparam logic [POS_W-1:0] POS_LONG_FST  = 4'd7;
  localparam logic [POS_W-1:0] POS_LONG_LST  = 4'd10;
  localparam logic [POS_W-1:0] POS_LONG_END  = 4'd11;
  localparam logic [POS_W-1:0] POS_STR_SCAN  = 4'd7;
  localparam logic [POS_W-1:0] POS_STR_TAIL  = 4'd8;

  // physical depth of the string store
  localparam int STORE_DEPTH = 32;

  // controller to datapath
  typedef struct packed {
    logic accept;   // input item taken this cycle
    logic rd;       // read string store at the char index
    logic ld_char;  // load read char into the output register
  } tvrp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic str_run;    // presented byte would start a non-empty string run
    logic out_free;   // output register can take a result this cycle
    logic char_last;  // char index points at the last char of the run
  } tvrp_sts_t;

endpackage

### rtl/tvrp_ctrl.sv
// tvrp_ctrl: controller of the typed value record parser
// depends on tvrp_pkg for the command and status structs
module tvrp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tvrp_pkg::tvrp_sts_t sts,
  output tvrp_pkg::tvrp_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IN = 3'b001,
    ST_RD = 3'b010,
    ST_LD = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IN) && sts.out_free;

  always_comb begin
    state_next  = state;
    cmd.accept  = 1'b0;
    cmd.rd      = 1'b0;
    cmd.ld_char = 1'b0;
    unique case (state)
      ST_IN: begin
        cmd.accept = in_valid && in_ready;
        if (cmd.accept && sts.str_run) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_LD;
      end
      ST_LD: begin
        if (sts.out_free) begin
          cmd.ld_char = 1'b1;
          state_next  = sts.char_last ? ST_IN : ST_RD;
        end
      end
      default: begin
        state_next = ST_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IN;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/tvrp_dpath.sv
// tvrp_dpath: record state, string store and output register
// depends on tvrp_pkg; driven by tvrp_ctrl commands
module tvrp_dpath #(
  parameter int MAX_STRING_LEN = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          data_byte,
  input  logic                end_of_buffer,
  input  logic                out_ready,
  input  tvrp_pkg::tvrp_cmd_t cmd,
  output tvrp_pkg::tvrp_sts_t sts,
  output logic                out_valid,
  output logic [7:0]          record_id,
  output logic [1:0]          kind,
  output logic [31:0]         payload_value,
  output logic                has_char,
  output logic                last
);

  localparam int STR_CAP = (MAX_STRING_LEN < tvrp_pkg::STORE_DEPTH) ?
                           MAX_STRING_LEN : tvrp_pkg::STORE_DEPTH;
  localparam int LW = $clog2(STR_CAP + 1);
  localparam int AW = (STR_CAP > 1) ? $clog2(STR_CAP) : 1;

  logic [tvrp_pkg::POS_W-1:0] pos, pos_next;
  logic [7:0]                 cur_id, id_next;
  logic [7:0]                 cur_type, type_next;
  logic [31:0]                acc, acc_next;
  logic [LW-1:0]              len, len_next;
  logic                       emitted, emitted_next;
  logic                       stopped, stopped_next;

  logic [7:0]    mem [STR_CAP];
  logic [7:0]    rd_data;
  logic [LW-1:0] idx;
  logic [LW-1:0] emit_len;

  logic        wr_en;
  logic        str_emit;
  logic        res_v;
  logic [1:0]  res_kind;
  logic [31:0] res_val;

  always_comb begin
    pos_next     = pos;
    id_next      = cur_id;
    type_next    = cur_type;
    acc_next     = acc;
    len_next     = len;
    emitted_next = emitted;
    stopped_next = stopped;
    wr_en        = 1'b0;
    str_emit     = 1'b0;
    res_v        = 1'b0;
    res_kind     = tvrp_pkg::KIND_INVALID;
    res_val      = '0;
    if (!stopped) begin
      if (pos == tvrp_pkg::POS_ID) begin
        pos_next     = tvrp_pkg::POS_TYPE;
        id_next      = data_byte;
        acc_next     = '0;
        len_next     = '0;
        emitted_next = 1'b0;
      end else if (pos == tvrp_pkg::POS_TYPE) begin
        type_next = data_byte;
        pos_next  = tvrp_pkg::POS_BODY;
        if (data_byte != tvrp_pkg::TYPE_NUM_SHORT && data_byte != tvrp_pkg::TYPE_NUM_LONG &&
            data_byte != tvrp_pkg::TYPE_STRING) begin
          res_v        = 1'b1;
          emitted_next = 1'b1;
          stopped_next = 1'b1;
        end
      end else if (cur_type == tvrp_pkg::TYPE_NUM_SHORT) begin
        if (pos <= tvrp_pkg::POS_SHORT_LST) begin
          acc_next = {acc[23:0], data_byte};
        end
        if (pos == tvrp_pkg::POS_SHORT_LST) begin
          res_v        = 1'b1;
          res_kind     = tvrp_pkg::KIND_NUMERIC;
          res_val      = acc_next;
          emitted_next = 1'b1;
        end
        pos_next = (pos >= tvrp_pkg::POS_SHORT_END) ? tvrp_pkg::POS_ID : pos + 1'b1;
      end else if (cur_type == tvrp_pkg::TYPE_NUM_LONG) begin
        if (pos >= tvrp_pkg::POS_LONG_FST && pos <= tvrp_pkg::POS_LONG_LST) begin
          acc_next = {acc[23:0], data_byte};
        end
        if (pos == tvrp_pkg::POS_LONG_LST) begin
          res_v        = 1'b1;
          res_kind     = tvrp_pkg::KIND_NUMERIC;
          res_val      = acc_next;
          emitted_next = 1'b1;
        end
        pos_next = (pos >= tvrp_pkg::POS_LONG_END) ? tvrp_pkg::POS_ID : pos + 1'b1;
      end else begin
        if (pos < tvrp_pkg::POS_STR_SCAN) begin
          pos_next = pos + 1'b1;
        end else if (pos == tvrp_pkg::POS_STR_SCAN) begin
          if (data_byte == 8'd0) begin
            str_emit     = !emitted;
            emitted_next = 1'b1;
            pos_next     = tvrp_pkg::POS_STR_TAIL;
          end else if (!emitted) begin
            if (len < LW'(STR_CAP)) begin
              wr_en    = 1'b1;
              len_next = len + 1'b1;
            end else begin
              res_v        = 1'b1;
              res_kind     = tvrp_pkg::KIND_TOO_LONG;
              emitted_next = 1'b1;
            end
          end
        end else begin
          pos_next = tvrp_pkg::POS_ID;
        end
      end
    end
    // empty string gives one result right away
    if (str_emit && len == '0) begin
      res_v    = 1'b1;
      res_kind = tvrp_pkg::KIND_STRING;
    end
    if (end_of_buffer) begin
      if (!stopped_next && pos_next >= tvrp_pkg::POS_BODY && !emitted_next) begin
        res_v    = 1'b1;
        res_kind = tvrp_pkg::KIND_INVALID;
        res_val  = '0;
      end
      pos_next     = tvrp_pkg::POS_ID;
      acc_next     = '0;
      len_next     = '0;
      emitted_next = 1'b0;
      stopped_next = 1'b0;
    end
  end

  assign sts.str_run   = str_emit && (len != '0);
  assign sts.out_free  = !out_valid || out_ready;
  assign sts.char_last = (idx + LW'(1)) == emit_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= tvrp_pkg::POS_ID;
      cur_id   <= '0;
      cur_type <= '0;
      acc      <= '0;
      len      <= '0;
      emitted  <= 1'b0;
      stopped  <= 1'b0;
    end else if (cmd.accept) begin
      pos      <= pos_next;
      cur_id   <= id_next;
      cur_type <= type_next;
      acc      <= acc_next;
      len      <= len_next;
      emitted  <= emitted_next;
      stopped  <= stopped_next;
    end
  end

  // string store and run counter
  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      mem[len[AW-1:0]] <= data_byte;
    end
    if (cmd.rd) begin
      rd_data <= mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && sts.str_run) begin
      idx      <= '0;
      emit_len <= len;
    end else if (cmd.ld_char) begin
      idx <= idx + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.accept && res_v) || cmd.ld_char) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && res_v) begin
      record_id     <= id_next;
      kind          <= res_kind;
      payload_value <= res_val;
      has_char      <= 1'b0;
      last          <= 1'b1;
    end else if (cmd.ld_char) begin
      record_id     <= cur_id;
      kind          <= tvrp_pkg::KIND_STRING;
      payload_value <= {24'd0, rd_data};
      has_char      <= 1'b1;
      last          <= sts.char_last;
    end
  end

`ifndef SYNTHESIS
  a_ld_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.ld_char |-> (!out_valid || out_ready))
    else $error("char loaded over a waiting result");
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && sts.str_run) |=> (idx == '0 && emit_len != '0))
    else $error("string run did not start at char zero");
  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(STR_CAP))
    else $error("string length beyond capacity");
  a_stop_emitted: assert property (@(posedge clk) disable iff (rst)
    stopped |-> emitted)
    else $error("parsing stopped without a result");
`endif

endmodule

### rtl/typed_value_record_parser.sv
// typed_value_record_parser: top level, controller plus datapath
// depends on tvrp_pkg, tvrp_ctrl and tvrp_dpath
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   data_byte, end_of_buffer
//   out      output     out_valid / out_ready record_id, kind, payload_value,
//                                             has_char, last
//
// one byte per cycle while the output register is empty or being taken
// a zero byte that ends a string of n chars holds off input until all n are loaded:
//   one store read and one output load per char, the string store read port
// a stalled output holds off input, the one output register parts the sides
// synchronous active-high reset clears record state and the output valid;
//   the string store is not cleared, only entries of the current string are read
module typed_value_record_parser #(
  parameter int MAX_STRING_LEN = 32
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  record_id,
  output logic [1:0]  kind,
  output logic [31:0] payload_value,
  output logic        has_char,
  output logic        last
);

  // command and status between controller and datapath
  tvrp_pkg::tvrp_cmd_t cmd;
  tvrp_pkg::tvrp_sts_t sts;

  // controller: byte intake and string run sequencing
  tvrp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: record decode, string store, output register
  tvrp_dpath #(
    .MAX_STRING_LEN (MAX_STRING_LEN)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .out_ready     (out_ready),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .record_id     (record_id),
    .kind          (kind),
    .payload_value (payload_value),
    .has_char      (has_char),
    .last          (last)
  );

endmodule

### test/testbench.sv
// testbench: self-checking bench for typed_value_record_parser
// drives byte buffers through the input handshake, predicts every result and checks each one
// depends on tvrp_pkg and typed_value_record_parser
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // string capacity of the block under test
  localparam int MAX_LEN = 32;
  localparam int STRING_CAP = (MAX_LEN < tvrp_pkg::STORE_DEPTH) ? MAX_LEN :
                              tvrp_pkg::STORE_DEPTH;

  // idle limit for the watchdog, receiver hold-off and bytes of random buffers
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_BYTES = 16;
  localparam int TAIL_CYCLES = 64;

  // one result as the block should give it
  typedef struct packed {
    logic [7:0]  record_id;
    logic [1:0]  kind;
    logic [31:0] payload_value;
    logic        has_char;
    logic        last;
  } parsed_value_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  record_id;
  logic [1:0]  kind;
  logic [31:0] payload_value;
  logic        has_char;
  logic        last;

  // expected results in arrival order
  parsed_value_t expected_values[$];
  // bytes of the buffer being built
  logic [7:0]    frame_q[$];

  int mismatch_count = 0;
  int quiet_cycles = 0;

  // both sides run without gaps while set
  bit steady = 1'b0;
  // set by a test, cleared by the receiver once its hold-off is over
  bit hold_req = 1'b0;

  // parser state as the predictor sees it
  logic [tvrp_pkg::POS_W-1:0] pr_pos;
  logic [7:0]  pr_id;
  logic [7:0]  pr_type;
  logic [31:0] pr_acc;
  logic [7:0]  pr_store[tvrp_pkg::STORE_DEPTH];
  logic [5:0]  pr_len;
  logic        pr_done;
  logic        pr_stopped;

  typed_value_record_parser #(
    .MAX_STRING_LEN(MAX_LEN)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .end_of_buffer(end_of_buffer),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .record_id(record_id),
    .kind(kind),
    .payload_value(payload_value),
    .has_char(has_char),
    .last(last)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // queue one result for the current record
  task automatic add_value(input logic [1:0] k, input logic [31:0] v, input logic hc,
                           input logic lst);
    parsed_value_t r;
    r.record_id = pr_id;
    r.kind = k;
    r.payload_value = v;
    r.has_char = hc;
    r.last = lst;
    expected_values.push_back(r);
  endtask

  // per-record state back to its start
  task automatic clear_record_state();
    pr_pos = tvrp_pkg::POS_ID;
    pr_acc = 32'd0;
    pr_len = 6'd0;
    pr_done = 1'b0;
  endtask

  // advance the parser by one accepted byte and queue what it emits
  task automatic parse_byte(input logic [7:0] b, input logic eob);
    logic [tvrp_pkg::POS_W-1:0] p;
    p = pr_pos;
    if (!pr_stopped) begin
      if (p == tvrp_pkg::POS_ID) begin
        // first byte of a record is its id
        clear_record_state();
        pr_id = b;
        pr_pos = tvrp_pkg::POS_TYPE;
      end else if (p == tvrp_pkg::POS_TYPE) begin
        pr_type = b;
        pr_pos = tvrp_pkg::POS_BODY;
        // unknown type: one invalid, rest of buffer ignored
        if (b != tvrp_pkg::TYPE_NUM_SHORT && b != tvrp_pkg::TYPE_NUM_LONG &&
            b != tvrp_pkg::TYPE_STRING) begin
          add_value(tvrp_pkg::KIND_INVALID, 32'd0, 1'b0, 1'b1);
          pr_done = 1'b1;
          pr_stopped = 1'b1;
        end
      end else if (pr_type == tvrp_pkg::TYPE_NUM_SHORT) begin
        if (p <= tvrp_pkg::POS_SHORT_LST) pr_acc = {pr_acc[23:0], b};
        if (p == tvrp_pkg::POS_SHORT_LST) begin
          add_value(tvrp_pkg::KIND_NUMERIC, pr_acc, 1'b0, 1'b1);
          pr_done = 1'b1;
        end
        pr_pos = (p >= tvrp_pkg::POS_SHORT_END) ? tvrp_pkg::POS_ID : p + 1'b1;
      end else if (pr_type == tvrp_pkg::TYPE_NUM_LONG) begin
        if (p >= tvrp_pkg::POS_LONG_FST && p <= tvrp_pkg::POS_LONG_LST)
          pr_acc = {pr_acc[23:0], b};
        if (p == tvrp_pkg::POS_LONG_LST) begin
          add_value(tvrp_pkg::KIND_NUMERIC, pr_acc, 1'b0, 1'b1);
          pr_done = 1'b1;
        end
        pr_pos = (p >= tvrp_pkg::POS_LONG_END) ? tvrp_pkg::POS_ID : p + 1'b1;
      end else begin
        // string record
        if (p < tvrp_pkg::POS_STR_SCAN) begin
          pr_pos = p + 1'b1;
        end else if (p == tvrp_pkg::POS_STR_SCAN) begin
          if (b == 8'd0) begin
            // terminator: emit the buffered run unless already reported
            if (!pr_done) begin
              if (pr_len == 6'd0) begin
                add_value(tvrp_pkg::KIND_STRING, 32'd0, 1'b0, 1'b1);
              end else begin
                for (int i = 0; i < int'(pr_len); i++) begin
                  add_value(tvrp_pkg::KIND_STRING, {24'd0, pr_store[i[4:0]]}, 1'b1,
                            (i == int'(pr_len) - 1));
                end
              end
            end
            pr_done = 1'b1;
            pr_pos = tvrp_pkg::POS_STR_TAIL;
          end else if (!pr_done) begin
            if (pr_len < 6'(STRING_CAP)) begin
              pr_store[pr_len[4:0]] = b;
              pr_len = pr_len + 6'd1;
            end else begin
              // overflow reported once, scan goes on to the zero byte
              add_value(tvrp_pkg::KIND_TOO_LONG, 32'd0, 1'b0, 1'b1);
              pr_done = 1'b1;
            end
          end
        end else begin
          pr_pos = tvrp_pkg::POS_ID;
        end
      end
    end
    // end of buffer: truncated record gives invalid, then everything restarts
    if (eob) begin
      if (!pr_stopped && pr_pos >= tvrp_pkg::POS_BODY && !pr_done)
        add_value(tvrp_pkg::KIND_INVALID, 32'd0, 1'b0, 1'b1);
      clear_record_state();
      pr_stopped = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // monitor: result check, prediction on accepted bytes, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    parsed_value_t w;
    if (rst) begin
      clear_record_state();
      pr_id = 8'd0;
      pr_type = 8'd0;
      pr_stopped = 1'b0;
      quiet_cycles = 0;
    end else begin
      // results first, so a new prediction never meets an early result
      if (out_valid && out_ready) begin
        if (expected_values.size() == 0) begin
          report_mismatch("result with none pending, id", 32'(record_id), 32'd0);
        end else begin
          w = expected_values.pop_front();
          if (record_id !== w.record_id)
            report_mismatch("record_id", 32'(record_id), 32'(w.record_id));
          if (kind !== w.kind) report_mismatch("kind", 32'(kind), 32'(w.kind));
          if (payload_value !== w.payload_value)
            report_mismatch("payload_value", payload_value, w.payload_value);
          if (has_char !== w.has_char)
            report_mismatch("has_char", 32'(has_char), 32'(w.has_char));
          if (last !== w.last) report_mismatch("last", 32'(last), 32'(w.last));
        end
      end
      if (in_valid && in_ready) parse_byte(data_byte, end_of_buffer);
      // watchdog: cycles with no item moving on either side
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random ready, long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req && !rst) begin
        // hold off while the sender keeps offering, counted here
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 33);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender and buffer builders
  // ---------------------------------------------------------------------------

  // offer one item and return at the edge that takes it
  task automatic send_byte(input logic [7:0] b, input logic eob);
    // each cycle idles with a one in three chance
    while (!steady && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_buffer <= eob;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // send the built buffer, end_of_buffer on its last byte
  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
  endtask

  // sender pauses until every expected result has come
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_values.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_byte(input int lo);
    rand_byte = 8'($urandom_range(lo, 255));
  endfunction

  // type 1: id, type, four value bytes, one filler
  task automatic put_short(input logic [7:0] id, input logic [31:0] v);
    frame_q.push_back(id);
    frame_q.push_back(tvrp_pkg::TYPE_NUM_SHORT);
    for (int i = 3; i >= 0; i--) frame_q.push_back(v[8*i +: 8]);
    frame_q.push_back(rand_byte(0));
  endtask

  // type 3: id, type, five skipped bytes, four value bytes, one filler
  task automatic put_long(input logic [7:0] id, input logic [31:0] v);
    frame_q.push_back(id);
    frame_q.push_back(tvrp_pkg::TYPE_NUM_LONG);
    repeat (5) frame_q.push_back(rand_byte(0));
    for (int i = 3; i >= 0; i--) frame_q.push_back(v[8*i +: 8]);
    frame_q.push_back(rand_byte(0));
  endtask

  // type 4: id, type, five skipped bytes, nonzero chars, zero, tail
  task automatic put_string(input logic [7:0] id, input int len);
    frame_q.push_back(id);
    frame_q.push_back(tvrp_pkg::TYPE_STRING);
    repeat (5) frame_q.push_back(rand_byte(0));
    repeat (len) frame_q.push_back(rand_byte(1));
    frame_q.push_back(8'h00);
    frame_q.push_back(rand_byte(0));
  endtask

  // mostly well-formed records with random content, some broken buffers
  task automatic build_random_frame();
    int nrec;
    int pick;
    int lp;
    int keep;
    logic [7:0] t;
    bit stopped;
    pick = $urandom_range(99);
    if (pick < 5) begin
      // lone byte, dropped
      frame_q.push_back(rand_byte(0));
    end else begin
      nrec = $urandom_range(1, 4);
      stopped = 1'b0;
      for (int r = 0; r < nrec && !stopped; r++) begin
        lp = $urandom_range(99);
        if (lp < 30) begin
          put_short(rand_byte(0), $urandom);
        end else if (lp < 55) begin
          put_long(rand_byte(0), $urandom);
        end else if (lp < 92) begin
          lp = $urandom_range(99);
          if (lp < 80) put_string(rand_byte(0), $urandom_range(0, 8));
          else if (lp < 93) put_string(rand_byte(0), $urandom_range(9, STRING_CAP));
          else put_string(rand_byte(0), $urandom_range(STRING_CAP + 1, STRING_CAP + 8));
        end else begin
          // unknown type then junk up to the end of the buffer
          t = rand_byte(0);
          while (t == tvrp_pkg::TYPE_NUM_SHORT || t == tvrp_pkg::TYPE_NUM_LONG ||
                 t == tvrp_pkg::TYPE_STRING) t = rand_byte(0);
          frame_q.push_back(rand_byte(0));
          frame_q.push_back(t);
          repeat ($urandom_range(0, 4)) frame_q.push_back(rand_byte(0));
          stopped = 1'b1;
        end
      end
      if (pick < 15) begin
        // truncated anywhere
        keep = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > keep) void'(frame_q.pop_back());
      end else if (pick < 25) begin
        // filler or tail missing
        void'(frame_q.pop_back());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // numeric extremes in both layouts
  task automatic test_numeric_records();
    put_short(8'hFF, 32'hFFFF_FFFF);
    put_long(8'hA5, 32'h8000_0001);
    send_frame();
    drain_results();
  endtask

  // empty string and extreme chars
  task automatic test_string_records();
    put_string(8'h11, 0);
    frame_q.push_back(8'h22);
    frame_q.push_back(tvrp_pkg::TYPE_STRING);
    repeat (5) frame_q.push_back(rand_byte(0));
    frame_q.push_back(8'h01);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'h80);
    frame_q.push_back(8'h00);
    frame_q.push_back(rand_byte(0));
    send_frame();
    drain_results();
  endtask

  // overflow after the store fills, framing kept; sent and taken with no gaps
  task automatic test_string_too_long();
    steady = 1'b1;
    put_string(8'h44, STRING_CAP + 1);
    put_short(8'h45, 32'h1234_5678);
    send_frame();
    drain_results();
    steady = 1'b0;
  endtask

  // unknown types: junk ignored to the end, and on the last byte itself
  task automatic test_unknown_type();
    frame_q = '{8'h51, 8'h02, 8'h01};
    send_frame();
    frame_q = '{8'h52, 8'hFF};
    send_frame();
    put_short(8'h53, 32'hCAFE_0001);
    frame_q.push_back(8'h54);
    frame_q.push_back(8'h00);
    send_frame();
    drain_results();
  endtask

  // truncated records and the lone byte
  task automatic test_truncated_and_lone();
    frame_q = '{8'h61, tvrp_pkg::TYPE_NUM_SHORT, 8'hAB};
    send_frame();
    frame_q = '{8'h62};
    send_frame();
    frame_q = '{8'h63, tvrp_pkg::TYPE_NUM_LONG};
    send_frame();
    // string cut during the scan, and cut right after the zero byte
    put_string(8'h65, 1);
    repeat (2) void'(frame_q.pop_back());
    send_frame();
    put_string(8'h66, 0);
    void'(frame_q.pop_back());
    send_frame();
    drain_results();
  endtask

  // records whose filler or tail is missing at the end of the buffer
  task automatic test_missing_tail();
    put_short(8'h71, 32'h0102_0304);
    void'(frame_q.pop_back());
    send_frame();
    put_string(8'h73, 1);
    void'(frame_q.pop_back());
    send_frame();
    drain_results();
  endtask

  // receiver holds off long while the sender keeps offering
  task automatic test_backpressure();
    hold_req = 1'b1;
    put_short(8'h82, $urandom);
    put_string(8'h84, 3);
    send_frame();
    drain_results();
    while (hold_req) @(posedge clk);
  endtask

  // random buffers with occasional pauses until drained
  task automatic test_random_buffers();
    int sent;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      build_random_frame();
      sent += frame_q.size();
      send_frame();
      if ($urandom_range(9) == 0) drain_results();
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    // reset held once, at the start
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_numeric_records();
    test_string_records();
    test_string_too_long();
    test_unknown_type();
    test_truncated_and_lone();
    test_missing_tail();
    test_backpressure();
    test_random_buffers();

    // quiet tail to catch stray results
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_values.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
